/* sv/tps_point_evaluator_macros.svh */
// Assertion macros used by the thin-plate-spline evaluator checker.
`ifndef TPS_POINT_EVALUATOR_MACROS_SVH
`define TPS_POINT_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tps_point_evaluator: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tps_point_evaluator: assertion failed");

`endif

/* sv/tps_pkg.sv */
// Shared types, constants and arithmetic helpers of the TPS evaluator.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int CoordW  = 32;
  localparam int IndexW  = 6;
  localparam int CountW  = 7;
  localparam int AffineN = 3;
  localparam int UW      = 56;   // kernel value U, signed Q40.16
  localparam int AccW    = 64;

  // ln2 in Q16
  localparam logic signed [17:0] Ln2Q16 = 18'sd45426;

  typedef enum logic [1:0] {
    FUNC_LOAD_POINT  = 2'd0,
    FUNC_LOAD_AFFINE = 2'd1,
    FUNC_EVAL        = 2'd2
  } func_e;

  // What a pipeline slot carries toward the accumulator
  typedef enum logic [1:0] {
    TERM_CONST = 2'd0,
    TERM_X     = 2'd1,
    TERM_Y     = 2'd2,
    TERM_POINT = 2'd3
  } term_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  capture;    // eval transaction: latch query, clear accumulator
    logic  wr_point;   // write control point memory
    logic  wr_affine;  // write affine term
    logic  issue;      // push one term into the pipeline
    term_e kind;
    logic  load_out;   // move accumulator into the output register
  } cmd_t;

  // log2 mantissa table, Q16, with the end point at index 16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v[63:31] != {33{v[63]}}) begin
      return v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

endpackage

/* sv/tps_in_if.sv */
// Input channel: valid/ready handshake with one command transaction.
`timescale 1ns / 1ps

interface tps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         index;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] wx;
  logic signed [31:0] wy;

  modport source (output valid, func, index, px, py, wx, wy, input ready);
  modport sink   (input valid, func, index, px, py, wx, wy, output ready);
endinterface

/* sv/tps_out_if.sv */
// Output channel: valid/ready handshake with one mapped point.
`timescale 1ns / 1ps

interface tps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] map_x;
  logic signed [31:0] map_y;

  modport source (output valid, map_x, map_y, input ready);
  modport sink   (input valid, map_x, map_y, output ready);
endinterface

/* sv/tps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tps_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/tps_datapath.sv */
// Kernel pipeline: distance, log2, U, weighted terms and saturating accumulator.
`timescale 1ns / 1ps

module tps_datapath #(
  parameter int MAX_POINTS = 64,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tps_pkg::cmd_t      cmd_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [5:0]         index_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] wx_i,
  input  logic signed [31:0] wy_i,
  output logic               busy_o,
  output logic signed [31:0] map_x_o,
  output logic signed [31:0] map_y_o
);
  localparam int NS = 13;  // pipeline depth from memory read to term

  // Point memory: {ctrl_x, ctrl_y, kern_wx, kern_wy}
  logic [127:0] rd_data;

  tps_ram #(.WIDTH(128), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_point),
    .waddr_i (AW'(index_i)),
    .wdata_i ({px_i, py_i, wx_i, wy_i}),
    .raddr_i (addr_i),
    .rdata_o (rd_data)
  );

  logic signed [31:0] aff_x_q [tps_pkg::AffineN];
  logic signed [31:0] aff_y_q [tps_pkg::AffineN];
  logic signed [31:0] qx_q, qy_q;
  logic [NS:1]        vld_q;
  tps_pkg::term_e     kind_q [1:NS];
  logic signed [63:0] acc_q;

  // Stage registers
  logic [31:0]        dx_q, dy_q;
  logic [63:0]        sx_q, sy_q;
  logic [63:0]        r2p_q [4:9];
  logic [7:0]         nz_q;
  logic [2:0]         pos_q [8];
  logic [5:0]         e6_q, e7_q;
  logic [6:10]        zp_q;
  logic [3:0]         idx_q;
  logic [15:0]        rem_q;
  logic signed [22:0] lg2_q;
  logic signed [23:0] lnv_q;
  logic signed [56:0] plo_q, phi_q;
  logic signed [tps_pkg::UW-1:0] u_q;
  logic signed [31:0] wxp_q [2:11];
  logic signed [31:0] wyp_q [2:11];
  logic signed [64:0] pxl_q, pyl_q;
  logic signed [55:0] pxh_q, pyh_q;
  logic signed [63:0] tx_q, ty_q;

  // Control state: slot valids and affine terms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int k = 0; k < tps_pkg::AffineN; k++) begin
        aff_x_q[k] <= '0;
        aff_y_q[k] <= '0;
      end
    end else begin
      vld_q <= {vld_q[NS-1:1], cmd_i.issue};
      if (cmd_i.wr_affine) begin
        aff_x_q[index_i[1:0]] <= wx_i;
        aff_y_q[index_i[1:0]] <= wy_i;
      end
    end
  end

  assign busy_o = |vld_q;

  // Stage 2: absolute coordinate differences
  logic signed [32:0] difx, dify, ndifx, ndify;
  always_comb begin
    difx  = {rd_data[127], rd_data[127:96]} - {qx_q[31], qx_q};
    dify  = {rd_data[95], rd_data[95:64]} - {qy_q[31], qy_q};
    ndifx = -difx;
    ndify = -dify;
  end

  // Stage 4: saturating r2 sum
  logic [64:0] r2sum;
  assign r2sum = {1'b0, sx_q} + {1'b0, sy_q};

  // Stage 5: per-byte leading-one search
  logic [7:0] nz_d;
  logic [2:0] pos_d [8];
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_d[g]  = |r2p_q[4][8*g +: 8];
      pos_d[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (r2p_q[4][8*g + b]) pos_d[g] = 3'(b);
      end
    end
  end

  // Stage 6: pick the top nonzero byte
  logic [5:0] e6_d;
  always_comb begin
    e6_d = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (nz_q[g]) e6_d = {3'(g), pos_q[g]};
    end
  end

  // Stage 7: normalize
  logic [63:0] mant;
  assign mant = r2p_q[6] << (6'd63 - e6_q);

  // Stage 8: table interpolation and exponent
  logic [16:0]       t0, t1, tdiff, frac;
  logic [32:0]       iprod;
  logic signed [6:0] eoff;
  always_comb begin
    t0    = tps_pkg::log2_tab({1'b0, idx_q});
    t1    = tps_pkg::log2_tab({1'b0, idx_q} + 5'd1);
    tdiff = t1 - t0;
    iprod = tdiff * rem_q;
    frac  = t0 + iprod[32:16];
    eoff  = $signed({1'b0, e7_q}) - 7'sd32;
  end

  // Stage 9: ln = log2 * ln2
  logic signed [40:0] lnp;
  assign lnp = lg2_q * tps_pkg::Ln2Q16;

  // Stage 11: U = floor(r2 * ln / 2^32)
  logic signed [56:0] usum;
  assign usum = phi_q + (plo_q >>> 32);

  // Stage 12: term select and weight products
  logic signed [tps_pkg::UW-1:0] usel;
  logic signed [31:0]            wsx, wsy;
  logic signed [32:0]            ulo;
  logic signed [23:0]            uhi;
  always_comb begin
    unique case (kind_q[11])
      tps_pkg::TERM_CONST: begin
        usel = tps_pkg::UW'(65536);
        wsx  = aff_x_q[0];
        wsy  = aff_y_q[0];
      end
      tps_pkg::TERM_X: begin
        usel = tps_pkg::UW'(qx_q);
        wsx  = aff_x_q[1];
        wsy  = aff_y_q[1];
      end
      tps_pkg::TERM_Y: begin
        usel = tps_pkg::UW'(qy_q);
        wsx  = aff_x_q[2];
        wsy  = aff_y_q[2];
      end
      default: begin
        usel = u_q;
        wsx  = wxp_q[11];
        wsy  = wyp_q[11];
      end
    endcase
    ulo = $signed({1'b0, usel[31:0]});
    uhi = usel[55:32];
  end

  // Stage 13: recombine partial products, shift by 24
  logic signed [87:0] fullx, fully;
  always_comb begin
    fullx = $signed({pxh_q, 32'd0}) + $signed({{23{pxl_q[64]}}, pxl_q});
    fully = $signed({pyh_q, 32'd0}) + $signed({{23{pyl_q[64]}}, pyl_q});
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      qx_q  <= px_i;
      qy_q  <= py_i;
      acc_q <= '0;
    end else if (vld_q[NS]) begin
      acc_q <= tps_pkg::sat_add64(acc_q, tx_q);
    end
    if (cmd_i.load_out) begin
      map_x_o <= tps_pkg::sat32(acc_q);
    end

    kind_q[1] <= cmd_i.kind;
    for (int k = 2; k <= NS; k++) kind_q[k] <= kind_q[k-1];

    wxp_q[2] <= rd_data[63:32];
    wyp_q[2] <= rd_data[31:0];
    for (int k = 3; k <= 11; k++) begin
      wxp_q[k] <= wxp_q[k-1];
      wyp_q[k] <= wyp_q[k-1];
    end

    dx_q <= difx[32] ? ndifx[31:0] : difx[31:0];
    dy_q <= dify[32] ? ndify[31:0] : dify[31:0];
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    r2p_q[4] <= r2sum[64] ? {64{1'b1}} : r2sum[63:0];
    for (int k = 5; k <= 9; k++) r2p_q[k] <= r2p_q[k-1];

    nz_q  <= nz_d;
    pos_q <= pos_d;
    e6_q  <= e6_d;
    zp_q[6] <= ~|nz_q;
    for (int k = 7; k <= 10; k++) zp_q[k] <= zp_q[k-1];

    e7_q  <= e6_q;
    idx_q <= mant[62:59];
    rem_q <= mant[58:43];
    lg2_q <= $signed({eoff, 16'd0}) + $signed({6'd0, frac});
    lnv_q <= lnp[39:16];
    plo_q <= $signed({1'b0, r2p_q[9][31:0]}) * lnv_q;
    phi_q <= $signed({1'b0, r2p_q[9][63:32]}) * lnv_q;
    u_q   <= zp_q[10] ? '0 : usum[tps_pkg::UW-1:0];

    pxl_q <= wsx * ulo;
    pxh_q <= wsx * uhi;
    pyl_q <= wsy * ulo;
    pyh_q <= wsy * uhi;
    tx_q  <= fullx[87:24];
    ty_q  <= fully[87:24];
  end

  // Y accumulator shares the term timing with X
  logic signed [63:0] accy_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      accy_q <= '0;
    end else if (vld_q[NS]) begin
      accy_q <= tps_pkg::sat_add64(accy_q, ty_q);
    end
    if (cmd_i.load_out) begin
      map_y_o <= tps_pkg::sat32(accy_q);
    end
  end
endmodule

/* sv/tps_ctrl.sv */
// Controller: handshakes, point count register and term issue sequencing.
`timescale 1ns / 1ps

module tps_ctrl #(
  parameter int MAX_POINTS = 64,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic [1:0]      in_func_i,
  input  logic [5:0]      in_index_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  logic            busy_i,
  output tps_pkg::cmd_t   cmd_o,
  output logic [AW-1:0]   addr_o
);
  localparam int CW0  = $clog2(MAX_POINTS + 1);
  localparam int CntW = (CW0 > tps_pkg::CountW) ? CW0 : tps_pkg::CountW;

  typedef enum logic [1:0] {S_IDLE, S_AFFINE, S_POINTS, S_DRAIN} state_e;

  state_e         state_q;
  logic [6:0]     pc_q;
  logic [CntW-1:0] pt_q, n_lim;
  logic           issue_q, out_valid_q;
  tps_pkg::term_e kind_q;
  logic           accept, is_eval, done;

  assign n_lim = (CntW'(pc_q) > CntW'(MAX_POINTS)) ? CntW'(MAX_POINTS) : CntW'(pc_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_eval    = (in_func_i == tps_pkg::FUNC_EVAL);
  assign done       = (state_q == S_DRAIN) && !busy_i && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.capture   = accept && is_eval;
    cmd_o.wr_point  = accept && (in_func_i == tps_pkg::FUNC_LOAD_POINT) &&
                      ({26'd0, in_index_i} < 32'(MAX_POINTS));
    cmd_o.wr_affine = accept && (in_func_i == tps_pkg::FUNC_LOAD_AFFINE) &&
                      ({26'd0, in_index_i} < 32'(tps_pkg::AffineN));
    cmd_o.issue     = issue_q;
    cmd_o.kind      = kind_q;
    cmd_o.load_out  = done;
  end

  assign addr_o      = pt_q[AW-1:0];
  assign out_valid_o = out_valid_q;

  // State, counters and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      pt_q        <= '0;
      issue_q     <= 1'b0;
      kind_q      <= tps_pkg::TERM_CONST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;

      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && is_eval) begin
            state_q <= S_AFFINE;
            issue_q <= 1'b1;
            kind_q  <= tps_pkg::TERM_CONST;
            pt_q    <= '0;
          end
        end
        S_AFFINE: begin
          priority case (kind_q)
            tps_pkg::TERM_CONST: kind_q <= tps_pkg::TERM_X;
            tps_pkg::TERM_X:     kind_q <= tps_pkg::TERM_Y;
            default: begin
              kind_q <= tps_pkg::TERM_POINT;
              if (n_lim == '0) begin
                issue_q <= 1'b0;
                state_q <= S_DRAIN;
              end else begin
                state_q <= S_POINTS;
              end
            end
          endcase
        end
        S_POINTS: begin
          if (pt_q + CntW'(1) == n_lim) begin
            issue_q <= 1'b0;
            state_q <= S_DRAIN;
          end else begin
            pt_q <= pt_q + CntW'(1);
          end
        end
        S_DRAIN: begin
          if (done) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/tps_point_evaluator.sv */
// Top level of the thin-plate-spline point evaluator.
//
//   channel   direction  transaction contents
//   in_if     sink       func, index, px, py, wx, wy
//   out_if    source     map_x, map_y (eval only)
//   cfg       write      point_count (cfg_we_i, cfg_wdata_i)
//
// Loads are written as they are accepted. An eval issues three affine
// terms and then one point per cycle into a 13-stage kernel pipeline fed
// by the point memory. rst_ni clears control state and the affine terms;
// the point memory holds garbage until loaded. A stalled result waits in
// the output register while loads are still accepted; a second eval waits
// for it before finishing.
`timescale 1ns / 1ps

module tps_point_evaluator #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  tps_in_if.sink      in_if,
  tps_out_if.source   out_if
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  tps_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  logic          busy;

  tps_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_if.valid),
    .in_func_i   (in_if.func),
    .in_index_i  (in_if.index),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .busy_i      (busy),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  tps_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .index_i (in_if.index),
    .px_i    (in_if.px),
    .py_i    (in_if.py),
    .wx_i    (in_if.wx),
    .wy_i    (in_if.wy),
    .busy_o  (busy),
    .map_x_o (out_if.map_x),
    .map_y_o (out_if.map_y)
  );
endmodule

/* sv/tps_checker.sv */
// Port-level checker for the TPS evaluator, bound to the top level.
`timescale 1ns / 1ps
`include "tps_point_evaluator_macros.svh"

module tps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] map_x_i,
  input logic signed [31:0] map_y_i
);
  // A pending result stays until taken
  `TPS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // A pending result does not change
  `TPS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(map_x_i) && $stable(map_y_i))
  // An eval transaction blocks the input while it runs
  `TPS_ASSERT_NEXT(a_eval_busy, in_valid_i && in_ready_i && (in_func_i == tps_pkg::FUNC_EVAL), !in_ready_i)
  // A new result never follows an input transaction directly
  `TPS_ASSERT_SAME(a_result_gap, $rose(out_valid_i), !$past(in_valid_i && in_ready_i))
endmodule

bind tps_point_evaluator tps_checker u_tps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_func_i   (in_if.func),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .map_x_i     (out_if.map_x),
  .map_y_i     (out_if.map_y)
);

/* tb/tb_top.sv */
// Testbench for the thin-plate-spline point evaluator: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_top;

  // func code with no operation behind it
  localparam logic [1:0] FuncUnused = 2'd3;

  // Predicts the mapped point of each eval and holds the mapped points still to come
  class tps_map_scoreboard;
    typedef struct {
      logic signed [31:0] map_x;
      logic signed [31:0] map_y;
    } mapped_t;

    longint  pt_x[64];
    longint  pt_y[64];
    longint  pt_wx[64];
    longint  pt_wy[64];
    longint  aff_x[3];
    longint  aff_y[3];
    int      n_active;
    mapped_t pending_maps[$];
    int      errors;
    int      maps_seen;
    logic [16:0] log_tab[17];

    function new();
      log_tab = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                  42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
      foreach (aff_x[i]) begin
        aff_x[i] = 0;
        aff_y[i] = 0;
      end
      n_active  = 0;
      errors    = 0;
      maps_seen = 0;
    endfunction

    // floor(+-(a*b) / 2^s), saturated to 64 bits signed
    function longint scaled_mul(logic [63:0] a, logic [63:0] b, bit neg, int s);
      logic [127:0] aa, bb, prod, q;
      bit rem_nz;
      aa = a;
      bb = b;
      prod = aa * bb;
      q = prod >> s;
      rem_nz = (prod & ((128'd1 << s) - 1)) != 0;
      if (!neg) begin
        if (q >= (128'd1 << 63)) return 64'sh7fff_ffff_ffff_ffff;
        return q[63:0];
      end
      if (q >= (128'd1 << 63)) return 64'sh8000_0000_0000_0000;
      if (rem_nz) q = q + 1;
      if (q >= (128'd1 << 63)) return 64'sh8000_0000_0000_0000;
      return -$signed(q[63:0]);
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'd0 - v : v;
    endfunction

    function longint signed_mul(longint a, longint b, int s);
      return scaled_mul(magnitude(a), magnitude(b), (a < 0) != (b < 0), s);
    endfunction

    function longint add_sat(longint a, longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      return s[63:0];
    endfunction

    // r2 * ln(r2) with a table log2, r2 unsigned Q32.32
    function longint kernel_value(logic [63:0] r2);
      int e;
      logic [63:0] m, frac;
      int idx;
      logic [15:0] rem;
      longint lg2, lnv;
      if (r2 == 0) return 0;
      e = 63;
      while (!r2[e]) e--;
      m = r2 << (63 - e);
      idx = m[62:59];
      rem = m[58:43];
      frac = log_tab[idx] + (((64'(log_tab[idx + 1] - log_tab[idx])) * rem) >> 16);
      lg2 = (longint'(e) - 32) * 65536 + longint'(frac);
      lnv = signed_mul(lg2, 45426, 16);
      return scaled_mul(r2, magnitude(lnv), lnv < 0, 32);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sh7fff_ffff) return 32'h7fff_ffff;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // One accepted input transaction
    function void note_input(logic [1:0] f, logic [5:0] idx, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] wx,
                             logic signed [31:0] wy);
      longint ax, ay, u, qx, qy;
      logic [63:0] dx, dy, sx, sy, r2;
      int n;
      mapped_t m;
      if (f == tps_pkg::FUNC_LOAD_POINT) begin
        pt_x[idx]  = px;
        pt_y[idx]  = py;
        pt_wx[idx] = wx;
        pt_wy[idx] = wy;
        return;
      end
      if (f == tps_pkg::FUNC_LOAD_AFFINE) begin
        if (idx < 3) begin
          aff_x[idx] = wx;
          aff_y[idx] = wy;
        end
        return;
      end
      if (f != tps_pkg::FUNC_EVAL) return;
      qx = px;
      qy = py;
      ax = signed_mul(aff_x[0], 1, 8);
      ax = add_sat(ax, signed_mul(aff_x[1], qx, 24));
      ax = add_sat(ax, signed_mul(aff_x[2], qy, 24));
      ay = signed_mul(aff_y[0], 1, 8);
      ay = add_sat(ay, signed_mul(aff_y[1], qx, 24));
      ay = add_sat(ay, signed_mul(aff_y[2], qy, 24));
      n = (n_active > 64) ? 64 : n_active;
      for (int i = 0; i < n; i++) begin
        dx = magnitude(pt_x[i] - qx);
        dy = magnitude(pt_y[i] - qy);
        sx = dx * dx;
        sy = dy * dy;
        r2 = (sx > ~sy) ? 64'hffff_ffff_ffff_ffff : sx + sy;
        u = kernel_value(r2);
        ax = add_sat(ax, signed_mul(pt_wx[i], u, 24));
        ay = add_sat(ay, signed_mul(pt_wy[i], u, 24));
      end
      m.map_x = clip32(ax);
      m.map_y = clip32(ay);
      pending_maps.push_back(m);
    endfunction

    // One accepted output transaction
    function void check_result(logic signed [31:0] mx, logic signed [31:0] my);
      mapped_t m;
      maps_seen++;
      if (pending_maps.size() == 0) begin
        $error("unexpected result map_x %h map_y %h", mx, my);
        errors++;
        return;
      end
      m = pending_maps.pop_front();
      if (mx !== m.map_x) begin
        $error("map_x expected %h actual %h", m.map_x, mx);
        errors++;
      end
      if (my !== m.map_y) begin
        $error("map_y expected %h actual %h", m.map_y, my);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         sent;
  bit         tail;

  tps_in_if  in_if ();
  tps_out_if out_if ();

  tps_point_evaluator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_if.sink),
    .out_if      (out_if.source)
  );

  tps_map_scoreboard sb = new();

  // Clock, 4 ns
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Transaction monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_input(in_if.func, in_if.index, in_if.px, in_if.py, in_if.wx, in_if.wy);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.map_x, out_if.map_y);
  end

  // Random word: mostly small values, some extremes, some full range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(0, 32'h0000_ffff) - 32'h0000_8000;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // Drive one input transaction; valid stays high until an idle burst
  task automatic send_item(logic [1:0] f, logic [5:0] idx, logic [31:0] px,
                           logic [31:0] py, logic [31:0] wx, logic [31:0] wy);
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.index <= idx;
    in_if.px    <= px;
    in_if.py    <= py;
    in_if.wx    <= wx;
    in_if.wy    <= wy;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
    if (!tail && ((sent / 64) % 3 != 1) && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Wait for every mapped point, let the pipeline drain, then set point_count
  task automatic set_count(logic [6:0] n);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_maps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.n_active = n;
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the tail
  initial begin
    bit held;
    held = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sb.maps_seen >= 40) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if (!tail && ((sb.maps_seen / 50) % 3 != 2) && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int r;
    logic [5:0] pidx;
    in_if.valid = 1'b0;
    in_if.func  = '0;
    in_if.index = '0;
    in_if.px    = '0;
    in_if.py    = '0;
    in_if.wx    = '0;
    in_if.wy    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    sent        = 0;
    tail        = 0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Affine only, no points active
    set_count(7'd0);
    send_item(tps_pkg::FUNC_LOAD_AFFINE, 6'd0, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
    send_item(tps_pkg::FUNC_LOAD_AFFINE, 6'd1, '0, '0, 32'h0100_0000, 32'h8000_0000);
    send_item(tps_pkg::FUNC_LOAD_AFFINE, 6'd2, '0, '0, 32'h7fff_ffff, 32'h0100_0000);
    send_item(tps_pkg::FUNC_LOAD_AFFINE, 6'd3, $urandom, $urandom, $urandom, $urandom);
    send_item(FuncUnused, 6'h3f, $urandom, $urandom, $urandom, $urandom);
    send_item(tps_pkg::FUNC_EVAL, 6'h3f, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, '0, '0, '0, '0);
    send_item(tps_pkg::FUNC_LOAD_AFFINE, 6'd0, '0, '0, 32'h0000_0100, 32'hffff_ff00);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'hffff_ffff, 32'h0000_0001, '0, '0);

    // Fill the point memory before any point becomes active
    for (int i = 0; i < 64; i++)
      send_item(tps_pkg::FUNC_LOAD_POINT, 6'(i), pick_word(), pick_word(), pick_word(),
                pick_word());
    send_item(tps_pkg::FUNC_LOAD_POINT, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000);
    send_item(tps_pkg::FUNC_LOAD_POINT, 6'd5, 32'h0001_0000, 32'hfffe_0000, 32'h0100_0000,
              32'hff00_0000);

    // Full set, zero distance and far corners
    set_count(7'd64);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'h0001_0000, 32'hfffe_0000, '0, '0);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    set_count(7'd127);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, 32'h0001_0000, 32'hfffe_0000, '0, '0);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, '0, '0, '0, '0);
    set_count(7'd1);
    send_item(tps_pkg::FUNC_EVAL, 6'd0, '0, '0, '0, '0);

    // Random part: mostly evals, with loads and unknown funcs mixed in
    for (int k = 0; k < 620; k++) begin
      if (k % 100 == 99) begin
        case ($urandom_range(0, 4))
          0:       set_count(7'd0);
          1:       set_count(7'd64);
          2:       set_count(7'd127);
          3:       set_count(7'd1);
          default: set_count(7'($urandom_range(2, 70)));
        endcase
      end
      if (k >= 530) tail = 1;
      r = $urandom_range(0, 99);
      pidx = 6'($urandom);
      if (r < 15)
        send_item(tps_pkg::FUNC_LOAD_POINT, pidx, pick_word(), pick_word(), pick_word(),
                  pick_word());
      else if (r < 25)
        send_item(tps_pkg::FUNC_LOAD_AFFINE,
                  6'($urandom_range(0, 3)) | (pidx & 6'h3c & {6{r[0]}}),
                  $urandom, $urandom, pick_word(), pick_word());
      else if (r < 29)
        send_item(FuncUnused, pidx, $urandom, $urandom, $urandom, $urandom);
      else
        send_item(tps_pkg::FUNC_EVAL, pidx, pick_word(), pick_word(), $urandom, $urandom);
    end
    in_if.valid <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (sb.pending_maps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_maps.size() == 0) begin
      $display("tps_point_evaluator: match");
    end else begin
      $display("tps_point_evaluator: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tps_point_evaluator: mismatch");
    $finish;
  end

endmodule
